// ===== src/lat_pkg.sv =====
// shared types, constants and helpers of the toroidal life automaton
`timescale 1ns / 1ps

package lat_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(CELLS);
  localparam int LW         = AW + 1;
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int SW         = 7;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_PLAY    = 2'd1,
    OP_RESTORE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_REST,
    ST_GEN,
    ST_COPY,
    ST_RESP
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  pixel;
    logic        last;
    logic [15:0] steps;
    logic [5:0]  row;
    logic [5:0]  col;
  } in_word_t;

  typedef struct packed {
    logic        cell_res;
    logic [31:0] generation;
    logic        board_loaded;
  } out_word_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(int'(r) * MAX_WIDTH + int'(c));
  endfunction

endpackage

// ===== src/lat_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module lat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/life_automaton_torus.sv =====
// top level of the toroidal life automaton with image seeding
`timescale 1ns / 1ps

// Conway's life on a wrap-around board of up to 64 by 64 cells, seeded from a
// grayscale image. Every accepted input word gives exactly one result word.
// Load words (pixels in raster order) and words that change nothing are
// answered from idle; a read goes through the response state. The word
// marked last sweeps all 4096 cells, thresholding the stored levels into the
// seed and live boards; a restore copies the seed back into the live board. A
// play word runs each generation through the live-board ram, which has one
// read port: nine reads plus one write to the next-board ram per cell, then a
// copy of the new board back into the live ram. A generation that changes
// nothing ends the run early; the count still moves by all steps (saturating).
// The user writes board size registers only while idle; it is not enforced.
module life_automaton_torus (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lat_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lat_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  import lat_pkg::*;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    bw_r, bh_r, used_w, used_h;
  logic [LW-1:0]    area, load_index_r;
  logic [7:0]       min_r, max_r;
  logic [31:0]      gen_r;
  logic [32:0]      gen_sum;
  logic             loaded_r;
  logic [15:0]      gens_left_r;
  logic             out_valid_r;
  out_word_t        out_data_r, res_data;
  logic             res_load, in_acc, quick, room, slot_free;

  // sweep and generation walk
  logic [RW-1:0]    r_r, nbr_row, ru, rd, lim_h_m1;
  logic [CW-1:0]    c_r, nbr_col, cl, cr, lim_w_m1;
  logic [AW-1:0]    lin_r, p_addr_r;
  logic             p_vld_r, p_use_r, end_r, last_cell, issue, on_board;
  logic [3:0]       k_r, cnt_r, cnt_tot;
  logic             cur_r, changed_r, nv, read_hit_r;
  logic [8:0]       level_sum;

  // memory ports
  logic             raw_we, raw_re, seed_we, seed_re, live_we, live_re, next_we, next_re;
  logic [AW-1:0]    live_raddr;
  logic [7:0]       raw_rdata;
  logic             seed_wdata, seed_rdata, live_wdata, live_rdata, next_rdata;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clamp the board size registers
  assign used_w = (bw_r < SW'(3)) ? SW'(3) : (bw_r > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : bw_r;
  assign used_h = (bh_r < SW'(3)) ? SW'(3) : (bh_r > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : bh_r;
  assign area   = LW'(used_w) * LW'(used_h);
  assign room   = load_index_r < area;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign in_acc    = in_valid && !in_stall;

  // items that finish in the cycle they are taken
  assign quick = ((in_data.op == OP_LOAD) && !in_data.last) ||
                 ((in_data.op == OP_PLAY) && (!loaded_r || (in_data.steps == 16'd0))) ||
                 ((in_data.op == OP_RESTORE) && !loaded_r);

  // whole memory for seeding and restore, used board for generations
  always_comb begin
    if (state_r == ST_FIN || state_r == ST_REST) begin
      lim_w_m1 = CW'(MAX_WIDTH - 1);
      lim_h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      lim_w_m1 = CW'(used_w - SW'(1));
      lim_h_m1 = RW'(used_h - SW'(1));
    end
  end

  assign last_cell = (r_r == lim_h_m1) && (c_r == lim_w_m1);
  assign issue     = !end_r;
  assign on_board  = (SW'(r_r) < used_h) && (SW'(c_r) < used_w);
  assign level_sum = {1'b0, min_r} + {1'b0, max_r};

  // wrapped neighbour coordinates
  assign ru = (r_r == '0) ? lim_h_m1 : r_r - RW'(1);
  assign rd = (r_r == lim_h_m1) ? '0 : r_r + RW'(1);
  assign cl = (c_r == '0) ? lim_w_m1 : c_r - CW'(1);
  assign cr = (c_r == lim_w_m1) ? '0 : c_r + CW'(1);

  always_comb begin
    nbr_row = r_r;
    nbr_col = c_r;
    case (k_r)
      4'd0: begin nbr_row = ru; nbr_col = cl; end
      4'd1: begin nbr_row = ru; nbr_col = c_r; end
      4'd2: begin nbr_row = ru; nbr_col = cr; end
      4'd3: begin nbr_row = r_r; nbr_col = cl; end
      4'd5: begin nbr_row = r_r; nbr_col = cr; end
      4'd6: begin nbr_row = rd; nbr_col = cl; end
      4'd7: begin nbr_row = rd; nbr_col = c_r; end
      4'd8: begin nbr_row = rd; nbr_col = cr; end
      default: begin nbr_row = r_r; nbr_col = c_r; end
    endcase
  end

  // last neighbour arrives in the decision cycle
  assign cnt_tot = cnt_r + {3'b0, live_rdata};
  assign nv      = (cnt_tot == 4'd3) || ((cnt_tot == 4'd2) && cur_r);
  assign gen_sum = {1'b0, gen_r} + {17'b0, in_data.steps};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            OP_LOAD:    state_nxt = in_data.last ? ST_FIN : ST_IDLE;
            OP_PLAY:    state_nxt = quick ? ST_IDLE : ST_GEN;
            OP_RESTORE: state_nxt = loaded_r ? ST_REST : ST_IDLE;
            OP_READ:    state_nxt = ST_RESP;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FIN, ST_REST: begin
        if (end_r) begin
          state_nxt = ST_RESP;
        end
      end
      ST_GEN: begin
        if (k_r == 4'd9 && last_cell) begin
          state_nxt = (changed_r || (nv != cur_r)) ? ST_COPY : ST_RESP;
        end
      end
      ST_COPY: begin
        if (end_r) begin
          state_nxt = (gens_left_r == 16'd1) ? ST_RESP : ST_GEN;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and result word
  always_comb begin
    raw_we     = 1'b0;
    raw_re     = 1'b0;
    seed_we    = 1'b0;
    seed_re    = 1'b0;
    live_we    = 1'b0;
    live_re    = 1'b0;
    next_we    = 1'b0;
    next_re    = 1'b0;
    live_raddr = cell_addr(nbr_row, nbr_col);
    seed_wdata = p_use_r && ({raw_rdata, 1'b0} < level_sum);
    live_wdata = seed_wdata;
    res_load   = 1'b0;
    res_data   = '{cell_res: 1'b0, generation: gen_r, board_loaded: loaded_r};
    case (state_r)
      ST_IDLE: begin
        raw_we     = in_acc && (in_data.op == OP_LOAD) && room;
        live_re    = in_acc && (in_data.op == OP_READ);
        live_raddr = cell_addr(RW'(in_data.row), CW'(in_data.col));
        res_load   = in_acc && quick;
      end
      ST_FIN: begin
        raw_re  = issue;
        seed_we = p_vld_r;
        live_we = p_vld_r;
      end
      ST_REST: begin
        seed_re    = issue;
        live_we    = p_vld_r;
        live_wdata = seed_rdata;
      end
      ST_GEN: begin
        live_re = k_r < 4'd9;
        next_we = k_r == 4'd9;
      end
      ST_COPY: begin
        next_re    = issue;
        live_we    = p_vld_r;
        live_wdata = next_rdata;
      end
      ST_RESP: begin
        res_load          = slot_free;
        res_data.cell_res = read_hit_r && live_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= 8'd255;
      max_r       <= 8'd0;
      load_index_r <= '0;
      gen_r       <= '0;
      loaded_r    <= 1'b0;
      bw_r        <= SW'(64);
      bh_r        <= SW'(64);
      end_r       <= 1'b0;
      p_vld_r     <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) begin
          bw_r <= cfg_data;
        end else begin
          bh_r <= cfg_data;
        end
      end

      if (res_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_data;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            r_r        <= '0;
            c_r        <= '0;
            lin_r      <= '0;
            k_r        <= '0;
            cnt_r      <= '0;
            changed_r  <= 1'b0;
            end_r      <= 1'b0;
            read_hit_r <= (in_data.op == OP_READ) && loaded_r &&
                          (SW'(in_data.row) < used_h) && (SW'(in_data.col) < used_w);
            case (in_data.op)
              OP_LOAD: begin
                if (room) begin
                  if (in_data.pixel < min_r) min_r <= in_data.pixel;
                  if (in_data.pixel > max_r) max_r <= in_data.pixel;
                  load_index_r <= load_index_r + LW'(1);
                end
              end
              OP_PLAY: begin
                if (loaded_r) begin
                  gen_r       <= gen_sum[32] ? 32'hFFFF_FFFF : gen_sum[31:0];
                  gens_left_r <= in_data.steps;
                end
              end
              OP_RESTORE: begin
                if (loaded_r) gen_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_FIN, ST_REST, ST_COPY: begin
          p_vld_r <= issue;
          if (issue) begin
            p_addr_r <= cell_addr(r_r, c_r);
            p_use_r  <= on_board && ({1'b0, lin_r} < load_index_r);
            if (on_board) lin_r <= lin_r + AW'(1);
            if (last_cell) begin
              end_r <= 1'b1;
              r_r   <= '0;
              c_r   <= '0;
            end else if (c_r == lim_w_m1) begin
              c_r <= '0;
              r_r <= r_r + RW'(1);
            end else begin
              c_r <= c_r + CW'(1);
            end
          end else begin
            end_r <= 1'b0;
            if (state_r == ST_FIN) begin
              min_r        <= 8'd255;
              max_r        <= 8'd0;
              load_index_r <= '0;
              gen_r        <= '0;
              loaded_r     <= 1'b1;
            end
            if (state_r == ST_COPY) begin
              gens_left_r <= gens_left_r - 16'd1;
              changed_r   <= 1'b0;
              k_r         <= '0;
              cnt_r       <= '0;
            end
          end
        end
        ST_GEN: begin
          if (k_r == 4'd5) begin
            cur_r <= live_rdata;
          end else if (k_r != 4'd0 && k_r != 4'd9) begin
            cnt_r <= cnt_tot;
          end
          if (k_r == 4'd9) begin
            k_r   <= '0;
            cnt_r <= '0;
            if (nv != cur_r) changed_r <= 1'b1;
            if (last_cell) begin
              r_r <= '0;
              c_r <= '0;
            end else if (c_r == lim_w_m1) begin
              c_r <= '0;
              r_r <= r_r + RW'(1);
            end else begin
              c_r <= c_r + CW'(1);
            end
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  lat_ram #(.WIDTH(8), .DEPTH(CELLS)) u_raw (
    .clk(clk), .we(raw_we), .waddr(load_index_r[AW-1:0]), .wdata(in_data.pixel),
    .re(raw_re), .raddr(lin_r), .rdata(raw_rdata)
  );

  lat_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seed (
    .clk(clk), .we(seed_we), .waddr(p_addr_r), .wdata(seed_wdata),
    .re(seed_re), .raddr(cell_addr(r_r, c_r)), .rdata(seed_rdata)
  );

  lat_ram #(.WIDTH(1), .DEPTH(CELLS)) u_live (
    .clk(clk), .we(live_we), .waddr(p_addr_r), .wdata(live_wdata),
    .re(live_re), .raddr(live_raddr), .rdata(live_rdata)
  );

  lat_ram #(.WIDTH(1), .DEPTH(CELLS)) u_next (
    .clk(clk), .we(next_we), .waddr(cell_addr(r_r, c_r)), .wdata(nv),
    .re(next_re), .raddr(cell_addr(r_r, c_r)), .rdata(next_rdata)
  );

  // a new result never overwrites one still waiting
  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting word");

  // once loaded, the board stays loaded
  a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r |=> loaded_r)
    else $error("loaded flag dropped");

  // neighbour walk never runs past the decision cycle
  a_gen_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> (k_r <= 4'd9))
    else $error("neighbour counter out of range");

  // live ram is never written while a generation reads it
  a_live_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> !live_we)
    else $error("live board written during generation");

endmodule

// ===== tb/sv/tb_life_automaton_torus.sv =====
// self-checking testbench for the toroidal life automaton
`timescale 1ns / 1ps

module tb_life_automaton_torus;
  import lat_pkg::*;

  localparam int IDLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;

  // no idling on either side once this is set
  bit quiet = 1'b0;
  int errors = 0;
  int items_sent = 0;
  out_word_t pending_words[$];

  // shadow copy of the board state
  bit         live_b[CELLS];
  bit         seed_b[CELLS];
  logic [7:0] levels[CELLS];
  int         lo_level, hi_level, fill_idx;
  logic [31:0] gen_count;
  bit         have_board;
  logic [6:0] width_reg, height_reg;

  always #10 clk = ~clk;

  life_automaton_torus u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int clamp_size(logic [6:0] v, int top);
    if (v < 3) return 3;
    if (v > top) return top;
    return int'(v);
  endfunction

  // one generation with wrap-around, returns whether anything changed
  function automatic bit step_board(int w, int h);
    bit nxt[CELLS];
    bit moved;
    int n, ru, rd, cl, cr;
    moved = 1'b0;
    nxt = live_b;
    for (int r = 0; r < h; r++) begin
      ru = (r + h - 1) % h;
      rd = (r + 1) % h;
      for (int c = 0; c < w; c++) begin
        cl = (c + w - 1) % w;
        cr = (c + 1) % w;
        n = live_b[ru*MAX_WIDTH+cl] + live_b[ru*MAX_WIDTH+c] + live_b[ru*MAX_WIDTH+cr]
          + live_b[r*MAX_WIDTH+cl] + live_b[r*MAX_WIDTH+cr]
          + live_b[rd*MAX_WIDTH+cl] + live_b[rd*MAX_WIDTH+c] + live_b[rd*MAX_WIDTH+cr];
        if (n == 3) nxt[r*MAX_WIDTH+c] = 1'b1;
        else if (n != 2) nxt[r*MAX_WIDTH+c] = 1'b0;
        if (nxt[r*MAX_WIDTH+c] != live_b[r*MAX_WIDTH+c]) moved = 1'b1;
      end
    end
    live_b = nxt;
    return moved;
  endfunction

  // advance the shadow state by one word and give the word it should return
  function automatic out_word_t life_response(in_word_t w_in);
    out_word_t res;
    int w, h, thr;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    res = '0;
    case (w_in.op)
      OP_LOAD: begin
        if (fill_idx < w * h) begin
          levels[fill_idx] = w_in.pixel;
          if (w_in.pixel < lo_level) lo_level = w_in.pixel;
          if (w_in.pixel > hi_level) hi_level = w_in.pixel;
          fill_idx++;
        end
        if (w_in.last) begin
          thr = lo_level + hi_level;
          for (int i = 0; i < CELLS; i++) seed_b[i] = 1'b0;
          for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
              if (r * w + c < fill_idx)
                seed_b[r*MAX_WIDTH+c] = (2 * int'(levels[r*w+c]) < thr);
          live_b = seed_b;
          lo_level = 255;
          hi_level = 0;
          fill_idx = 0;
          gen_count = '0;
          have_board = 1'b1;
        end
      end
      OP_PLAY: begin
        if (have_board) begin
          for (int i = 0; i < int'(w_in.steps); i++)
            if (!step_board(w, h)) break;
          if ({1'b0, gen_count} + 33'(w_in.steps) > 33'hFFFF_FFFF) gen_count = '1;
          else gen_count = gen_count + 32'(w_in.steps);
        end
      end
      OP_RESTORE: begin
        if (have_board) begin
          live_b = seed_b;
          gen_count = '0;
        end
      end
      default: begin
        if (have_board && w_in.row < h && w_in.col < w)
          res.cell_res = live_b[int'(w_in.row)*MAX_WIDTH + int'(w_in.col)];
      end
    endcase
    res.generation   = gen_count;
    res.board_loaded = have_board;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor: prediction on input words, checking on result words
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
      else height_reg = cfg_data;
    end
    if (rst_n && in_valid && !in_stall)
      pending_words = {pending_words, life_response(in_data)};
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_data.cell_res != want.cell_res)
          report_mismatch("cell_res", out_data.cell_res, want.cell_res);
        if (out_data.generation != want.generation)
          report_mismatch("generation", out_data.generation, want.generation);
        if (out_data.board_loaded != want.board_loaded)
          report_mismatch("board_loaded", out_data.board_loaded, want.board_loaded);
      end
    end
  end

  // receiver stall in random bursts
  always @(negedge clk) begin
    static int burst = 0;
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    static int idle_cycles = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_life_automaton_torus failed");
      $finish;
    end
  end

  // send one word; valid stays up straight into the next word unless a gap is drawn
  task automatic send_word(op_t op, logic [7:0] pix = '0, logic lst = 1'b0,
                           logic [15:0] stp = '0, logic [5:0] r = '0, logic [5:0] c = '0);
    in_word_t w;
    w.op = op; w.pixel = pix; w.last = lst; w.steps = stp; w.row = r; w.col = c;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_data  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // hold off until every result has come back, then a short tail
  task automatic drain;
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_size(logic idx, logic [6:0] v);
    drain();
    cfg_index = idx;
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // play, restore and read with no board yet
  task automatic test_no_board;
    send_word(OP_PLAY, 8'h00, 1'b0, 16'hFFFF);
    send_word(OP_RESTORE);
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd0, 6'd0);
  endtask

  // clamped sizes, short image, reads off the board, step extremes
  task automatic test_short_image;
    write_size(CFG_WIDTH, 7'd0);
    write_size(CFG_HEIGHT, 7'd1);
    send_word(OP_LOAD, 8'd0);
    send_word(OP_LOAD, 8'd255);
    send_word(OP_LOAD, 8'd128);
    send_word(OP_LOAD, 8'd127);
    send_word(OP_LOAD, 8'd10, 1'b1);
    for (int c = 0; c < 4; c++) send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd1, 6'(c));
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd63, 6'd2);
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd0, 6'd3);
    send_word(OP_PLAY, 8'h00, 1'b0, 16'h0000);
    // a 3x3 torus dies out within three generations, so the full step count stays cheap
    send_word(OP_PLAY, 8'h00, 1'b0, 16'hFFFF);
    send_word(OP_READ);
    send_word(OP_RESTORE);
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd1, 6'd0);
  endtask

  // size grows after the load: new area reads dead
  task automatic test_resize_after_load;
    write_size(CFG_WIDTH, 7'd64);
    write_size(CFG_HEIGHT, 7'd3);
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd2, 6'd63);
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd1, 6'd0);
    send_word(OP_PLAY, 8'h00, 1'b0, 16'd1);
    send_word(OP_READ, 8'h00, 1'b0, 16'h0000, 6'd1, 6'd1);
  endtask

  function automatic logic [7:0] rand_level;
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(252, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random phases: mostly a well-formed image then a mix of play/read/restore and stray loads
  task automatic test_random(int target);
    int w, h, npix, nops, sel;
    while (items_sent < target) begin
      if (items_sent > target - target / 6) quiet = 1'b1;
      w = $urandom_range(3, 10);
      h = $urandom_range(3, 10);
      if ($urandom_range(0, 15) == 0) begin
        w = $urandom_range(16, 24);
        h = $urandom_range(3, 6);
      end
      write_size(CFG_WIDTH, 7'(w));
      write_size(CFG_HEIGHT, 7'(h));
      if ($urandom_range(0, 4) != 0) begin
        npix = w * h + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, w * h);
        for (int i = 0; i < npix; i++)
          send_word(OP_LOAD, rand_level(), i == npix - 1, 16'($urandom()));
      end
      // sometimes move the size without reloading
      if ($urandom_range(0, 5) == 0) begin
        write_size(CFG_WIDTH, 7'($urandom_range(0, 127)));
        write_size(CFG_HEIGHT, 7'($urandom_range(3, 12)));
      end
      nops = $urandom_range(8, 30);
      for (int i = 0; i < nops; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 14)
          send_word(OP_PLAY, 8'($urandom()), 1'($urandom()), 16'($urandom_range(0, 5)));
        else if (sel < 22)
          send_word(OP_RESTORE, 8'($urandom()), 1'b0, 16'($urandom()));
        else if (sel < 25)
          send_word(OP_LOAD, rand_level(), 1'($urandom_range(0, 3) == 0));
        else if (sel < 40)
          send_word(OP_READ, 8'($urandom()), 1'($urandom()), 16'($urandom()),
                    6'($urandom()), 6'($urandom()));
        else
          send_word(OP_READ, 8'h00, 1'b0, 16'h0000,
                    6'($urandom_range(0, h - 1)), 6'($urandom_range(0, w - 1)));
      end
      // after each phase the sender waits for every result
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      live_b[i] = 1'b0; seed_b[i] = 1'b0; levels[i] = '0;
    end
    lo_level = 255; hi_level = 0; fill_idx = 0;
    gen_count = '0; have_board = 1'b0;
    width_reg = 7'd64; height_reg = 7'd64;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_no_board();
    test_short_image();
    test_resize_after_load();
    test_random(1650);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0)
      $display("tb_life_automaton_torus passed");
    else
      $display("tb_life_automaton_torus failed");
    $finish;
  end

endmodule
